@@ rtl/core/sdsh_pkg.sv @@
// Shared types and constants for the SD SPI block host sequencer.
`default_nettype none
package sdsh_pkg;

  typedef enum logic [4:0] {
    PH_IDLE, PH_FILL, PH_CMD_BUSY, PH_CMD_FRAME, PH_CMD_R1, PH_CMD_TAIL_OK,
    PH_CMD_TAIL_FAIL, PH_RD_TOKEN, PH_RD_DATA, PH_RD_CRC, PH_WR_DUMMY,
    PH_WR_TOKEN, PH_WR_DATA, PH_WR_CRC, PH_WR_RESP, PH_WR_TAIL_OK, PH_WR_TAIL_BAD
  } phase_t;

  typedef enum logic [1:0] {
    OP_INIT = 2'd0, OP_READ = 2'd1, OP_WRITE = 2'd2, OP_XCHG = 2'd3
  } opcode_t;

  localparam logic [1:0] CFG_BUSY_TIMEOUT = 2'd0;
  localparam logic [1:0] CFG_RETRY_LIMIT  = 2'd1;
  localparam logic [1:0] CFG_FILL_BYTES   = 2'd2;

  localparam logic [3:0] ST_OK          = 4'd0;
  localparam logic [3:0] ST_BUSY_TMO    = 4'd1;
  localparam logic [3:0] ST_NO_R1       = 4'd2;
  localparam logic [3:0] ST_CMD0_BAD    = 4'd3;
  localparam logic [3:0] ST_CMD1_BAD    = 4'd4;
  localparam logic [3:0] ST_CMD1_TMO    = 4'd5;
  localparam logic [3:0] ST_REJECTED    = 4'd6;
  localparam logic [3:0] ST_TOKEN_TMO   = 4'd7;
  localparam logic [3:0] ST_WR_REFUSED  = 4'd8;

  localparam logic [7:0] BYTE_IDLE   = 8'hFF;
  localparam logic [7:0] BYTE_TOKEN  = 8'hFE;
  localparam logic [7:0] BYTE_CMD    = 8'h40;
  localparam logic [7:0] BYTE_CRC    = 8'h95;
  localparam logic [7:0] R1_IDLE     = 8'h01;
  localparam logic [5:0] CMD_GO_IDLE = 6'd0;
  localparam logic [5:0] CMD_INIT    = 6'd1;
  localparam logic [5:0] CMD_READ    = 6'd17;
  localparam logic [5:0] CMD_WRITE   = 6'd24;
  localparam logic [3:0] DRESP_OK    = 4'd5;
  localparam logic [9:0] BLOCK_BYTES = 10'd512;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [22:0] block_address;
    logic [7:0]  rx_byte;
    logic [7:0]  write_byte;
  } item_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       cs_low;
    logic       data_request;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       done_res;
    logic [3:0] status;
    logic [7:0] card_response;
    logic       high_speed;
  } result_t;

endpackage
`default_nettype wire

@@ rtl/core/sdsh_front.sv @@
// Front end: accept words and queue them for the sequencer.
`default_nettype none
module sdsh_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire sdsh_pkg::item_t in_item,
  output logic                q_valid,
  input  wire logic           q_ready,
  output sdsh_pkg::item_t     q_item
);
  import sdsh_pkg::*;

  item_t      mem_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       wp_r, rp_r;
  logic       push, pop;

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = mem_r[rp_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_comb begin
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= in_item;
  end
endmodule
`default_nettype wire

@@ rtl/core/sdsh_back.sv @@
// Back end: card sequencer and result register.
`default_nettype none
module sdsh_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            q_valid,
  output logic                 q_ready,
  input  wire sdsh_pkg::item_t q_item,
  input  wire logic [15:0]     busy_timeout,
  input  wire logic [15:0]     retry_limit,
  input  wire logic [7:0]      fill_bytes,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output sdsh_pkg::result_t    out_res
);
  import sdsh_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [1:0]  oper_r, oper_nxt;
  logic [15:0] wait_r, wait_nxt, retry_r, retry_nxt;
  logic [9:0]  bcnt_r, bcnt_nxt;
  logic [5:0]  cidx_r, cidx_nxt;
  logic [31:0] carg_r, carg_nxt;
  logic [2:0]  fpos_r, fpos_nxt;
  logic [7:0]  resp_r, resp_nxt;
  result_t     res, res_r;
  logic        vld_r, step;
  logic [15:0] tmo, rlim;
  logic [7:0]  fill;
  logic [7:0]  rx, wb;
  logic [2:0]  fp1;

  assign tmo  = (busy_timeout == 16'd0) ? 16'd1 : busy_timeout;
  assign rlim = (retry_limit == 16'd0) ? 16'd1 : retry_limit;
  assign fill = (fill_bytes == 8'd0) ? 8'd1 : fill_bytes;
  assign rx   = q_item.rx_byte;
  assign wb   = q_item.write_byte;
  assign fp1  = fpos_r + 3'd1;

  assign q_ready   = !vld_r || out_ready;
  assign step      = q_valid && q_ready;
  assign out_valid = vld_r;
  assign out_res   = res_r;

  function automatic logic [7:0] frame_byte(input logic [2:0] pos, input logic [5:0] idx,
                                            input logic [31:0] arg);
    logic [7:0] b;
    unique case (pos)
      3'd0:    b = BYTE_CMD | {2'b00, idx};
      3'd1:    b = arg[31:24];
      3'd2:    b = arg[23:16];
      3'd3:    b = arg[15:8];
      3'd4:    b = arg[7:0];
      default: b = BYTE_CRC;
    endcase
    return b;
  endfunction

  always_comb begin
    phase_nxt = phase_r;
    oper_nxt  = oper_r;
    wait_nxt  = wait_r;
    retry_nxt = retry_r;
    bcnt_nxt  = bcnt_r;
    cidx_nxt  = cidx_r;
    carg_nxt  = carg_r;
    fpos_nxt  = fpos_r;
    resp_nxt  = resp_r;
    res       = '0;
    if (q_item.opcode != OP_XCHG) begin
      oper_nxt  = q_item.opcode;
      resp_nxt  = 8'd0;
      wait_nxt  = 16'd0;
      retry_nxt = 16'd0;
      fpos_nxt  = 3'd0;
      res.tx_valid = 1'b1;
      res.tx_byte  = BYTE_IDLE;
      if (q_item.opcode == OP_INIT) begin
        bcnt_nxt  = 10'd1;
        phase_nxt = PH_FILL;
      end else begin
        bcnt_nxt  = 10'd0;
        cidx_nxt  = (q_item.opcode == OP_READ) ? CMD_READ : CMD_WRITE;
        carg_nxt  = {q_item.block_address, 9'd0};
        wait_nxt  = 16'd1;
        phase_nxt = PH_CMD_BUSY;
        res.cs_low = 1'b1;
      end
    end else begin
      res.cs_low = 1'b1;
      unique case (phase_r)
        PH_IDLE: begin
          res.cs_low = 1'b0;
        end
        PH_FILL: begin
          res.tx_valid = 1'b1;
          res.tx_byte  = BYTE_IDLE;
          if (bcnt_r < {2'b00, fill}) begin
            bcnt_nxt   = bcnt_r + 10'd1;
            res.cs_low = 1'b0;
          end else begin
            cidx_nxt  = CMD_GO_IDLE;
            carg_nxt  = 32'd0;
            wait_nxt  = 16'd1;
            phase_nxt = PH_CMD_BUSY;
          end
        end
        PH_CMD_BUSY: begin
          if (rx == BYTE_IDLE) begin
            fpos_nxt     = 3'd0;
            phase_nxt    = PH_CMD_FRAME;
            res.tx_valid = 1'b1;
            res.tx_byte  = frame_byte(3'd0, cidx_r, carg_r);
          end else if (wait_r >= tmo) begin
            phase_nxt = PH_IDLE;
            res.done_res = 1'b1;
            res.status   = ST_BUSY_TMO;
            res.card_response = resp_r;
          end else begin
            wait_nxt     = wait_r + 16'd1;
            res.tx_valid = 1'b1;
            res.tx_byte  = BYTE_IDLE;
          end
        end
        PH_CMD_FRAME: begin
          res.tx_valid = 1'b1;
          if (fpos_r < 3'd5) begin
            fpos_nxt    = fp1;
            res.tx_byte = frame_byte(fp1, cidx_r, carg_r);
          end else begin
            wait_nxt    = 16'd1;
            phase_nxt   = PH_CMD_R1;
            res.tx_byte = BYTE_IDLE;
          end
        end
        PH_CMD_R1: begin
          res.tx_valid = 1'b1;
          res.tx_byte  = BYTE_IDLE;
          if (rx != BYTE_IDLE) begin
            resp_nxt  = rx;
            phase_nxt = PH_CMD_TAIL_OK;
          end else if (wait_r >= tmo) begin
            resp_nxt  = 8'd0;
            phase_nxt = PH_CMD_TAIL_FAIL;
          end else begin
            wait_nxt = wait_r + 16'd1;
          end
        end
        PH_CMD_TAIL_OK: begin
          res.card_response = resp_r;
          if (oper_r == OP_INIT) begin
            if (cidx_r == CMD_GO_IDLE) begin
              if (resp_r != R1_IDLE) begin
                phase_nxt = PH_IDLE;
                res.done_res = 1'b1;
                res.status   = ST_CMD0_BAD;
              end else begin
                retry_nxt = 16'd1;
                cidx_nxt  = CMD_INIT;
                carg_nxt  = 32'd0;
                wait_nxt  = 16'd1;
                phase_nxt = PH_CMD_BUSY;
                res.tx_valid = 1'b1;
                res.tx_byte  = BYTE_IDLE;
              end
            end else if (resp_r == 8'd0) begin
              phase_nxt = PH_IDLE;
              res.done_res   = 1'b1;
              res.status     = ST_OK;
              res.high_speed = 1'b1;
            end else if (resp_r == R1_IDLE) begin
              if (retry_r >= rlim) begin
                phase_nxt = PH_IDLE;
                res.done_res = 1'b1;
                res.status   = ST_CMD1_TMO;
              end else begin
                retry_nxt = retry_r + 16'd1;
                cidx_nxt  = CMD_INIT;
                carg_nxt  = 32'd0;
                wait_nxt  = 16'd1;
                phase_nxt = PH_CMD_BUSY;
                res.tx_valid = 1'b1;
                res.tx_byte  = BYTE_IDLE;
              end
            end else begin
              phase_nxt = PH_IDLE;
              res.done_res = 1'b1;
              res.status   = ST_CMD1_BAD;
            end
          end else if (resp_r != 8'd0) begin
            phase_nxt = PH_IDLE;
            res.done_res = 1'b1;
            res.status   = ST_REJECTED;
          end else begin
            res.tx_valid = 1'b1;
            res.tx_byte  = BYTE_IDLE;
            if (oper_r == OP_READ) begin
              wait_nxt  = 16'd1;
              phase_nxt = PH_RD_TOKEN;
            end else begin
              phase_nxt = PH_WR_DUMMY;
            end
          end
          if (!res.done_res) res.card_response = 8'd0;
        end
        PH_CMD_TAIL_FAIL: begin
          phase_nxt = PH_IDLE;
          res.done_res = 1'b1;
          res.status   = ST_NO_R1;
          res.card_response = resp_r;
        end
        PH_RD_TOKEN: begin
          if (rx == BYTE_TOKEN) begin
            bcnt_nxt  = 10'd1;
            phase_nxt = PH_RD_DATA;
            res.tx_valid = 1'b1;
            res.tx_byte  = BYTE_IDLE;
          end else if (wait_r >= tmo) begin
            phase_nxt = PH_IDLE;
            res.done_res = 1'b1;
            res.status   = ST_TOKEN_TMO;
            res.card_response = resp_r;
          end else begin
            wait_nxt = wait_r + 16'd1;
            res.tx_valid = 1'b1;
            res.tx_byte  = BYTE_IDLE;
          end
        end
        PH_RD_DATA: begin
          res.read_valid = 1'b1;
          res.read_byte  = rx;
          res.tx_valid   = 1'b1;
          res.tx_byte    = BYTE_IDLE;
          if (bcnt_r < BLOCK_BYTES) begin
            bcnt_nxt = bcnt_r + 10'd1;
          end else begin
            bcnt_nxt  = 10'd1;
            phase_nxt = PH_RD_CRC;
          end
        end
        PH_RD_CRC: begin
          if (bcnt_r < 10'd3) begin
            bcnt_nxt = bcnt_r + 10'd1;
            res.tx_valid = 1'b1;
            res.tx_byte  = BYTE_IDLE;
          end else begin
            phase_nxt = PH_IDLE;
            res.done_res = 1'b1;
            res.status   = ST_OK;
            res.card_response = resp_r;
          end
        end
        PH_WR_DUMMY: begin
          phase_nxt = PH_WR_TOKEN;
          res.tx_valid     = 1'b1;
          res.tx_byte      = BYTE_TOKEN;
          res.data_request = 1'b1;
        end
        PH_WR_TOKEN: begin
          bcnt_nxt  = 10'd1;
          phase_nxt = PH_WR_DATA;
          res.tx_valid     = 1'b1;
          res.tx_byte      = wb;
          res.data_request = 1'b1;
        end
        PH_WR_DATA: begin
          res.tx_valid = 1'b1;
          if (bcnt_r < BLOCK_BYTES) begin
            bcnt_nxt = bcnt_r + 10'd1;
            res.tx_byte      = wb;
            res.data_request = (bcnt_r + 10'd1) < BLOCK_BYTES;
          end else begin
            bcnt_nxt  = 10'd1;
            phase_nxt = PH_WR_CRC;
            res.tx_byte = BYTE_IDLE;
          end
        end
        PH_WR_CRC: begin
          res.tx_valid = 1'b1;
          res.tx_byte  = BYTE_IDLE;
          if (bcnt_r < 10'd2) bcnt_nxt = bcnt_r + 10'd1;
          else phase_nxt = PH_WR_RESP;
        end
        PH_WR_RESP: begin
          res.tx_valid = 1'b1;
          res.tx_byte  = BYTE_IDLE;
          phase_nxt = (rx[3:0] == DRESP_OK) ? PH_WR_TAIL_OK : PH_WR_TAIL_BAD;
        end
        PH_WR_TAIL_OK: begin
          phase_nxt = PH_IDLE;
          res.done_res = 1'b1;
          res.status   = ST_OK;
          res.card_response = resp_r;
        end
        PH_WR_TAIL_BAD: begin
          phase_nxt = PH_IDLE;
          res.done_res = 1'b1;
          res.status   = ST_WR_REFUSED;
          res.card_response = resp_r;
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
      if (!res.tx_valid) res.cs_low = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      oper_r  <= 2'd0;
      wait_r  <= 16'd0;
      retry_r <= 16'd0;
      bcnt_r  <= 10'd0;
      cidx_r  <= 6'd0;
      carg_r  <= 32'd0;
      fpos_r  <= 3'd0;
      resp_r  <= 8'd0;
      vld_r   <= 1'b0;
    end else begin
      if (step) begin
        phase_r <= phase_nxt;
        oper_r  <= oper_nxt;
        wait_r  <= wait_nxt;
        retry_r <= retry_nxt;
        bcnt_r  <= bcnt_nxt;
        cidx_r  <= cidx_nxt;
        carg_r  <= carg_nxt;
        fpos_r  <= fpos_nxt;
        resp_r  <= resp_nxt;
      end
      if (q_ready) vld_r <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) res_r <= res;
  end
endmodule
`default_nettype wire

@@ rtl/core/sd_spi_block_host_sequencer.sv @@
// Top level of the SD SPI-mode single-block host sequencer.
// Each input word is one SPI byte exchange (or a start) and yields one result word.
// A two-entry queue feeds a one-step sequencer with a registered result, so one
// word per clock is sustained while out_ready is high.
`default_nettype none
module sd_spi_block_host_sequencer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_opcode,
  input  wire logic [22:0] in_block_address,
  input  wire logic [7:0]  in_rx_byte,
  input  wire logic [7:0]  in_write_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_tx_valid,
  output logic [7:0]       out_tx_byte,
  output logic             out_cs_low,
  output logic             out_data_request,
  output logic             out_read_valid,
  output logic [7:0]       out_read_byte,
  output logic             out_done_res,
  output logic [3:0]       out_status,
  output logic [7:0]       out_card_response,
  output logic             out_high_speed
);
  import sdsh_pkg::*;

  logic [15:0] busy_tmo_r, retry_lim_r;
  logic [7:0]  fill_r;
  item_t       in_item, q_item;
  result_t     res;
  logic        q_valid, q_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_tmo_r  <= 16'd16384;
      retry_lim_r <= 16'd16384;
      fill_r      <= 8'd80;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_BUSY_TIMEOUT) busy_tmo_r <= cfg_data;
      if (cfg_index == CFG_RETRY_LIMIT) retry_lim_r <= cfg_data;
      if (cfg_index == CFG_FILL_BYTES) fill_r <= cfg_data[7:0];
    end
  end

  assign in_item = '{opcode: in_opcode, block_address: in_block_address,
                     rx_byte: in_rx_byte, write_byte: in_write_byte};

  sdsh_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_item(in_item), .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
  );

  sdsh_back u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
    .busy_timeout(busy_tmo_r), .retry_limit(retry_lim_r), .fill_bytes(fill_r),
    .out_valid(out_valid), .out_ready(out_ready), .out_res(res)
  );

  assign out_tx_valid      = res.tx_valid;
  assign out_tx_byte       = res.tx_byte;
  assign out_cs_low        = res.cs_low;
  assign out_data_request  = res.data_request;
  assign out_read_valid    = res.read_valid;
  assign out_read_byte     = res.read_byte;
  assign out_done_res      = res.done_res;
  assign out_status        = res.status;
  assign out_card_response = res.card_response;
  assign out_high_speed    = res.high_speed;
endmodule
`default_nettype wire

@@ rtl/core/sdsh_checker.sv @@
// Port-level checker for the sequencer, bound to the top level.
`default_nettype none
module sdsh_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       out_tx_valid,
  input wire logic       out_done_res,
  input wire logic       out_high_speed,
  input wire logic       out_read_valid,
  input wire logic       out_cs_low,
  input wire logic [3:0] out_status
);
  import sdsh_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_done_no_tx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> !out_tx_valid && !out_cs_low) else $error("done with tx");
  a_hs_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_high_speed |-> out_done_res && out_status == ST_OK) else $error("hs");
  a_read_tx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_read_valid |-> out_tx_valid && !out_done_res) else $error("read");
endmodule

bind sd_spi_block_host_sequencer sdsh_checker u_chk (
  .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_ready(out_ready),
  .out_tx_valid(out_tx_valid), .out_done_res(out_done_res),
  .out_high_speed(out_high_speed), .out_read_valid(out_read_valid),
  .out_cs_low(out_cs_low), .out_status(out_status)
);
`default_nettype wire
